### rtl/tod_pkg.sv
// Shared types, constants and helpers of the time-of-day clock.
package tod_pkg;

    localparam logic       CMD_TICK = 1'b0;
    localparam logic       CMD_BYTE = 1'b1;

    localparam logic [5:0] SEC_PER_MIN   = 6'd60;
    localparam logic [7:0] MIN_PER_HOUR  = 8'd60;
    localparam logic [7:0] HOURS_PER_DAY = 8'd24;
    localparam logic [7:0] ASCII_ZERO    = 8'd48;

    localparam logic [7:0] CHAR_H = 8'h68;
    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_C = 8'h63;
    localparam logic [7:0] CHAR_D = 8'h64;

    localparam logic [1:0] MODE_HANDS    = 2'd0;
    localparam logic [1:0] MODE_CURVED   = 2'd1;
    localparam logic [1:0] MODE_STRAIGHT = 2'd2;

    localparam logic [7:0] TPS_RESET    = 8'd5;
    localparam logic [7:0] MINUTE_RESET = 8'd10;
    localparam logic [7:0] HOUR_RESET   = 8'd11;

    // Set-sequence positions.
    localparam logic [2:0] POS_IDLE    = 3'd0;
    localparam logic [2:0] POS_H_TENS  = 3'd1;
    localparam logic [2:0] POS_H_UNITS = 3'd2;
    localparam logic [2:0] POS_M_TENS  = 3'd3;
    localparam logic [2:0] POS_M_UNITS = 3'd4;

    typedef struct packed {
        logic [7:0] hours;
        logic [7:0] minutes;
        logic [5:0] seconds;
        logic [1:0] display_mode;
    } t_tod_time;

    // Multiply by ten modulo 256 with two shifts and an add.
    function automatic logic [7:0] times_ten(input logic [7:0] value);
        return {value[4:0], 3'b000} + {value[6:0], 1'b0};
    endfunction

endpackage

### rtl/tod_if.sv
// Valid/ready channel interfaces for input items and result items.
interface tod_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface tod_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] hours;
    logic [7:0] minutes;
    logic [5:0] seconds;
    logic [1:0] display_mode;

    modport source (output valid, output hours, output minutes, output seconds,
                    output display_mode, input ready);
    modport sink   (input valid, input hours, input minutes, input seconds,
                    input display_mode, output ready);
endinterface

### rtl/tod_core.sv
// Clock state registers and the single-item update logic.
module tod_core
    import tod_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_command,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_ticks_per_second,
    output t_tod_time  o_next
);

    logic [7:0] r_tick_count;
    logic [5:0] r_second_count;
    logic [7:0] r_minute_count;
    logic [7:0] r_hour_count;
    logic [1:0] r_mode_reg;
    logic [2:0] r_parse_position;
    logic [7:0] r_digit_store [3];

    logic [7:0] n_tick_count;
    logic [5:0] n_second_count;
    logic [7:0] n_minute_count;
    logic [7:0] n_hour_count;
    logic [1:0] n_mode_reg;
    logic [2:0] n_parse_position;

    logic [7:0] digit;
    logic [7:0] tick_inc;
    logic [5:0] sec_inc;
    logic [7:0] min_step;
    logic [7:0] hour_step;
    logic       store_digit;
    logic [1:0] store_index;

    assign digit       = i_rx_byte - ASCII_ZERO;
    assign tick_inc    = r_tick_count + 8'd1;
    assign store_index = r_parse_position[1:0] - 2'd1;

    always_comb begin
        n_tick_count     = r_tick_count;
        n_second_count   = r_second_count;
        n_minute_count   = r_minute_count;
        n_hour_count     = r_hour_count;
        n_mode_reg       = r_mode_reg;
        n_parse_position = r_parse_position;
        store_digit      = 1'b0;
        sec_inc          = r_second_count + 6'd1;
        min_step         = r_minute_count;
        hour_step        = r_hour_count;

        if (i_command == CMD_TICK) begin
            n_tick_count = tick_inc;
            if (tick_inc >= i_ticks_per_second) begin
                // One second passes; each roll check runs on every second.
                n_tick_count = 8'd0;
                if (sec_inc == SEC_PER_MIN) begin
                    n_second_count = 6'd0;
                    min_step       = r_minute_count + 8'd1;
                end else begin
                    n_second_count = sec_inc;
                end
                if (min_step == MIN_PER_HOUR) begin
                    min_step  = 8'd0;
                    hour_step = r_hour_count + 8'd1;
                end
                if (hour_step == HOURS_PER_DAY) begin
                    hour_step = 8'd0;
                end
                n_minute_count = min_step;
                n_hour_count   = hour_step;
            end
        end else begin
            case (r_parse_position)
                POS_IDLE: begin
                    if (i_rx_byte == CHAR_H) begin
                        n_parse_position = POS_H_TENS;
                    end else if (i_rx_byte == CHAR_A) begin
                        n_mode_reg = MODE_HANDS;
                    end else if (i_rx_byte == CHAR_C) begin
                        n_mode_reg = MODE_CURVED;
                    end else if (i_rx_byte == CHAR_D) begin
                        n_mode_reg = MODE_STRAIGHT;
                    end
                end
                POS_H_TENS, POS_H_UNITS, POS_M_TENS: begin
                    store_digit      = 1'b1;
                    n_parse_position = r_parse_position + 3'd1;
                end
                POS_M_UNITS: begin
                    n_parse_position = POS_IDLE;
                    n_hour_count     = times_ten(r_digit_store[0]) + r_digit_store[1];
                    n_minute_count   = times_ten(r_digit_store[2]) + digit;
                end
                default: begin
                    // Unreachable positions behave as idle, without the set command.
                    if (i_rx_byte == CHAR_A) begin
                        n_mode_reg = MODE_HANDS;
                    end else if (i_rx_byte == CHAR_C) begin
                        n_mode_reg = MODE_CURVED;
                    end else if (i_rx_byte == CHAR_D) begin
                        n_mode_reg = MODE_STRAIGHT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count     <= 8'd0;
            r_second_count   <= 6'd0;
            r_minute_count   <= MINUTE_RESET;
            r_hour_count     <= HOUR_RESET;
            r_mode_reg       <= MODE_HANDS;
            r_parse_position <= POS_IDLE;
        end else if (i_step) begin
            r_tick_count     <= n_tick_count;
            r_second_count   <= n_second_count;
            r_minute_count   <= n_minute_count;
            r_hour_count     <= n_hour_count;
            r_mode_reg       <= n_mode_reg;
            r_parse_position <= n_parse_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && store_digit && (i_command == CMD_BYTE)) begin
            r_digit_store[store_index] <= digit;
        end
    end

    assign o_next.hours        = n_hour_count;
    assign o_next.minutes      = n_minute_count;
    assign o_next.seconds      = n_second_count;
    assign o_next.display_mode = n_mode_reg;

endmodule

### rtl/serial_set_time_of_day_clock.sv
// Top level of the time-of-day clock: input register, state update, result register.
// Every input item, a sub-second tick or a received serial byte, yields one result item
// carrying the hours, minutes, seconds and display mode after that item. An item is
// registered at the input, then applied to the clock state and placed in the result
// register together, once that register is free or being emptied; one item is taken in
// every cycle while results are being taken. A stalled result register holds the pipeline,
// and the input keeps accepting while its own register is free or moving.
// The ticks-per-second register resets to 5 and should be written only while idle.
module serial_set_time_of_day_clock
    import tod_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    tod_in_if.sink            i_in,
    tod_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata
);

    logic       r_in_valid;
    logic       r_in_command;
    logic [7:0] r_in_rx_byte;
    logic       r_out_valid;
    t_tod_time  r_out;
    logic [7:0] r_ticks_per_second;

    logic       step;
    t_tod_time  next_time;

    // The registered item moves on when the result register is empty or being emptied.
    assign step       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step;

    tod_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (step),
        .i_command          (r_in_command),
        .i_rx_byte          (r_in_rx_byte),
        .i_ticks_per_second (r_ticks_per_second),
        .o_next             (next_time)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_second <= TPS_RESET;
        end else if (i_cfg_we) begin
            r_ticks_per_second <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_command <= i_in.command;
            r_in_rx_byte <= i_in.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= next_time;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.hours        = r_out.hours;
    assign o_out.minutes      = r_out.minutes;
    assign o_out.seconds      = r_out.seconds;
    assign o_out.display_mode = r_out.display_mode;

endmodule

### rtl/tod_check.sv
// Port-level checks for the time-of-day clock, bound to the top level.
module tod_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [5:0] i_seconds,
    input logic [1:0] i_display_mode
);

    // A stalled result item keeps its seconds and mode.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_seconds)
            && $stable(i_display_mode))
        else $error("result item changed while stalled");

    // Every accepted item is followed by a valid result item at the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> ##2 i_out_valid)
        else $error("no result two cycles after an accepted item");

    // The seconds counter rolls over before it reaches sixty.
    a_seconds_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_seconds < 6'd60)
        else $error("seconds out of range");

    // Only three display modes can be selected.
    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_display_mode != 2'd3)
        else $error("display mode out of range");

endmodule

bind serial_set_time_of_day_clock tod_check u_tod_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_seconds      (o_out.seconds),
    .i_display_mode (o_out.display_mode)
);
